FILE: hw/rtl/frame_interval_pacer_smoother_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef FRAME_INTERVAL_PACER_SMOOTHER_MACROS_SVH
`define FRAME_INTERVAL_PACER_SMOOTHER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FIPS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define FIPS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/fips_pkg.sv
`default_nettype none

package fips_pkg;

  localparam int RAW_W    = 32;
  localparam int WAIT_W   = 20;
  localparam int STEP_W   = 32;
  localparam int FRAME_W  = 64;
  localparam int RATE_W   = 10;
  localparam int WIN_W    = 7;
  localparam int SCALE_W  = 16;
  localparam int PROD_W   = STEP_W + SCALE_W;
  localparam int PERIOD_W = 20;

  localparam int unsigned MICROS_PER_SECOND = 1000000;
  localparam logic [SCALE_W-1:0] SCALE_ONE = 16'd256;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_CAP_ACTIVE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CAP_INACTIVE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FLOOR_RATE   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SMOOTH_WIN   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SCALE        = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAP_GO,
    S_CAP_WT,
    S_FLR_GO,
    S_FLR_WT,
    S_HIST,
    S_SUM,
    S_AVG_GO,
    S_AVG_WT,
    S_MUL,
    S_OUT
  } fips_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fips_in_if.sv
`default_nettype none

interface fips_in_if;
  import fips_pkg::*;

  logic              valid;
  logic              ready;
  logic [RAW_W-1:0]  raw_interval_us;
  logic              app_active;

  modport source (output valid, output raw_interval_us, output app_active, input ready);
  modport sink   (input valid, input raw_interval_us, input app_active, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/fips_out_if.sv
`default_nettype none

interface fips_out_if;
  import fips_pkg::*;

  logic                valid;
  logic                ready;
  logic [WAIT_W-1:0]   wait_us;
  logic [STEP_W-1:0]   step_us;
  logic [STEP_W-1:0]   scaled_step_us;
  logic [FRAME_W-1:0]  frame_number;

  modport source (output valid, output wait_us, output step_us, output scaled_step_us,
                  output frame_number, input ready);
  modport sink   (input valid, input wait_us, input step_us, input scaled_step_us,
                  input frame_number, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/fips_div.sv
`default_nettype none

module fips_div #(
  parameter int DDW = 38,
  parameter int DVW = 10,
  parameter int LW  = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [DDW-1:0]   dividend,
  input  wire logic [DVW-1:0]   divisor,
  input  wire logic [LW-1:0]    len,
  output fips_pkg::div_stat_t   stat,
  output logic      [DDW-1:0]   quotient
);
  import fips_pkg::*;

`include "frame_interval_pacer_smoother_macros.svh"

  logic           busy_r;
  logic           done_r;
  logic [LW-1:0]  cnt_r;
  logic [DDW-1:0] dvd_r;
  logic [DDW-1:0] q_r;
  logic [DVW-1:0] rem_r;
  logic [DVW-1:0] dsr_r;

  logic [DVW:0]   rem_sh;
  logic [DVW:0]   diff;
  logic           qbit_nxt;
  logic [DVW-1:0] rem_nxt;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[DDW-1]};
    diff     = rem_sh - {1'b0, dsr_r};
    qbit_nxt = ~diff[DVW];
    rem_nxt  = qbit_nxt ? diff[DVW-1:0] : rem_sh[DVW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= len;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == LW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      q_r   <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DDW-2:0], 1'b0};
      q_r   <= {q_r[DDW-2:0], qbit_nxt};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

  `FIPS_ASSERT_IMP(a_div_done_idle, clk, rst_n, done_r, !busy_r, "divider done while busy")
  `FIPS_ASSERT_NXT(a_div_last_done, clk, rst_n, busy_r && (cnt_r == LW'(1)), done_r,
                   "divider missed done")
  `FIPS_ASSERT_NXT(a_div_start_busy, clk, rst_n, start && !busy_r && (len != '0), busy_r,
                   "divider failed to start")

endmodule

`default_nettype wire

FILE: hw/rtl/frame_interval_pacer_smoother.sv
// Channel   Dir  Handshake            Payload
// in_chan   in   valid/ready          raw_interval_us[31:0], app_active
// out_chan  out  valid/ready          wait_us[19:0], step_us, scaled_step_us, frame_number[63:0]
// cfg_*     in   APB write/read       5 registers at 4*i, 32-bit data
//
// Between one accepted beat and the next the block runs up to two period divisions and a
// DDW-bit mean division (DDW = 32 + log2 depth) on the shared restoring divider (one quotient
// bit a cycle), plus n history reads (n = active window).
// Skip a division or the averaging when its setting is off.
// Synchronous active-low reset clears control and configuration; the history needs no clear.
// in_chan is ready only while idle; a result waits in the output register under a stall
// and the next frame is accepted meanwhile.
`default_nettype none

module frame_interval_pacer_smoother #(
  parameter int HISTORY_DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  fips_in_if.sink                                in_chan,
  fips_out_if.source                             out_chan,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [fips_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [fips_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [fips_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                   cfg_pready
);
  import fips_pkg::*;

`include "frame_interval_pacer_smoother_macros.svh"

  localparam int DEPTH = HISTORY_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW    = $clog2(DEPTH + 1);
  localparam int DDW   = RAW_W + $clog2(DEPTH);
  localparam int DVW   = (FW > RATE_W) ? FW : RATE_W;
  localparam int LW    = $clog2(DDW + 1);
  localparam logic [DDW-1:0] MICROS_ALIGNED =
    DDW'(MICROS_PER_SECOND) << (DDW - PERIOD_W);

  // configuration
  logic [RATE_W-1:0]  cap_act_r;
  logic [RATE_W-1:0]  cap_inact_r;
  logic [RATE_W-1:0]  floor_r;
  logic [WIN_W-1:0]   win_r;
  logic [SCALE_W-1:0] scale_r;
  logic [REG_IDX_W-1:0] cfg_idx;
  logic               cfg_wr;

  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_act_r   <= '0;
      cap_inact_r <= '0;
      floor_r     <= '0;
      win_r       <= '0;
      scale_r     <= SCALE_ONE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CAP_ACTIVE:   cap_act_r   <= cfg_pwdata[RATE_W-1:0];
        REG_CAP_INACTIVE: cap_inact_r <= cfg_pwdata[RATE_W-1:0];
        REG_FLOOR_RATE:   floor_r     <= cfg_pwdata[RATE_W-1:0];
        REG_SMOOTH_WIN:   win_r       <= cfg_pwdata[WIN_W-1:0];
        REG_SCALE:        scale_r     <= cfg_pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CAP_ACTIVE:   cfg_prdata = CFG_DATA_W'(cap_act_r);
      REG_CAP_INACTIVE: cfg_prdata = CFG_DATA_W'(cap_inact_r);
      REG_FLOOR_RATE:   cfg_prdata = CFG_DATA_W'(floor_r);
      REG_SMOOTH_WIN:   cfg_prdata = CFG_DATA_W'(win_r);
      REG_SCALE:        cfg_prdata = CFG_DATA_W'(scale_r);
      default:          cfg_prdata = '0;
    endcase
  end

  // sequencer and datapath
  fips_state_t state_r, state_nxt;

  logic [RAW_W-1:0]   raw_r, raw_nxt;
  logic               act_r, act_nxt;
  logic [RAW_W-1:0]   elapsed_r, elapsed_nxt;
  logic [WAIT_W-1:0]  wait_r, wait_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [AW-1:0]      head_r, head_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic [FW-1:0]      cnt_r, cnt_nxt;
  logic [DDW-1:0]     sum_r, sum_nxt;
  logic               acc_v_r, acc_v_nxt;
  logic [FRAME_W-1:0] frame_r, frame_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [WAIT_W-1:0]  out_wait_r, out_wait_nxt;
  logic [STEP_W-1:0]  out_step_r, out_step_nxt;
  logic [STEP_W-1:0]  out_scaled_r, out_scaled_nxt;
  logic [FRAME_W-1:0] out_frame_r, out_frame_nxt;

  logic [RAW_W-1:0]   hist_mem [DEPTH];
  logic [RAW_W-1:0]   rd_data_r;
  logic               wr_en;
  logic               rd_en;

  logic               div_start;
  logic [DDW-1:0]     div_dvd;
  logic [DVW-1:0]     div_dsr;
  logic [LW-1:0]      div_len;
  div_stat_t          div_stat;
  logic [DDW-1:0]     div_q;

  logic [RATE_W-1:0]  cap;
  logic [FW-1:0]      n_w;
  logic [FW:0]        held;
  logic               hist_wrap;
  logic [RAW_W-1:0]   period;
  logic               slot_free;
  logic [AW-1:0]      head_inc;
  logic [AW-1:0]      ptr_dec;

  assign cap       = (!act_r && (cap_inact_r < cap_act_r)) ? cap_inact_r : cap_act_r;
  assign n_w       = (int'(win_r) > DEPTH) ? FW'(DEPTH) : FW'(win_r);
  assign held      = {1'b0, fill_r} + 1'b1;
  assign hist_wrap = held > {1'b0, n_w};
  assign period    = RAW_W'(div_q[PERIOD_W-1:0]);
  assign slot_free = !out_valid_r || out_chan.ready;
  assign head_inc  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign ptr_dec   = (ptr_r == '0) ? AW'(DEPTH - 1) : ptr_r - 1'b1;

  fips_div #(
    .DDW (DDW),
    .DVW (DVW),
    .LW  (LW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .len      (div_len),
    .stat     (div_stat),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_chan.valid) state_nxt = S_CAP_GO;
      S_CAP_GO: state_nxt = (cap == '0) ? S_FLR_GO : S_CAP_WT;
      S_CAP_WT: if (div_stat.done) state_nxt = S_FLR_GO;
      S_FLR_GO: state_nxt = (floor_r == '0) ? S_HIST : S_FLR_WT;
      S_FLR_WT: if (div_stat.done) state_nxt = S_HIST;
      S_HIST:   state_nxt = (win_r != '0 && hist_wrap) ? S_SUM : S_MUL;
      S_SUM:    if (cnt_r == n_w && !acc_v_r) state_nxt = S_AVG_GO;
      S_AVG_GO: state_nxt = S_AVG_WT;
      S_AVG_WT: if (div_stat.done) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_OUT;
      S_OUT:    if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    raw_nxt        = raw_r;
    act_nxt        = act_r;
    elapsed_nxt    = elapsed_r;
    wait_nxt       = wait_r;
    step_nxt       = step_r;
    prod_nxt       = prod_r;
    head_nxt       = head_r;
    ptr_nxt        = ptr_r;
    fill_nxt       = fill_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    acc_v_nxt      = 1'b0;
    frame_nxt      = frame_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_wait_nxt   = out_wait_r;
    out_step_nxt   = out_step_r;
    out_scaled_nxt = out_scaled_r;
    out_frame_nxt  = out_frame_r;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    div_start      = 1'b0;
    div_dvd        = MICROS_ALIGNED;
    div_dsr        = DVW'(cap);
    div_len        = LW'(PERIOD_W);

    if (acc_v_r) sum_nxt = sum_r + DDW'(rd_data_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          raw_nxt     = in_chan.raw_interval_us;
          act_nxt     = in_chan.app_active;
          elapsed_nxt = in_chan.raw_interval_us;
          wait_nxt    = '0;
        end
      end
      S_CAP_GO: begin
        div_start = (cap != '0);
      end
      S_CAP_WT: begin
        if (div_stat.done && (raw_r < period)) begin
          wait_nxt    = WAIT_W'(period - raw_r);
          elapsed_nxt = period;
        end
      end
      S_FLR_GO: begin
        div_dsr   = DVW'(floor_r);
        div_start = (floor_r != '0);
      end
      S_FLR_WT: begin
        if (div_stat.done && (elapsed_r > period)) elapsed_nxt = period;
      end
      S_HIST: begin
        step_nxt = elapsed_r;
        if (win_r != '0) begin
          wr_en    = 1'b1;
          ptr_nxt  = head_r;
          head_nxt = head_inc;
          if (hist_wrap) begin
            fill_nxt = n_w;
            cnt_nxt  = '0;
            sum_nxt  = '0;
          end else begin
            fill_nxt = held[FW-1:0];
          end
        end
      end
      S_SUM: begin
        if (cnt_r != n_w) begin
          rd_en     = 1'b1;
          acc_v_nxt = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
          ptr_nxt   = ptr_dec;
        end
      end
      S_AVG_GO: begin
        div_dvd   = sum_r;
        div_dsr   = DVW'(n_w);
        div_len   = LW'(DDW);
        div_start = 1'b1;
      end
      S_AVG_WT: begin
        if (div_stat.done) step_nxt = div_q[STEP_W-1:0];
      end
      S_MUL: begin
        prod_nxt = PROD_W'(step_r) * PROD_W'(scale_r);
      end
      S_OUT: begin
        if (slot_free) begin
          frame_nxt      = frame_r + 1'b1;
          out_valid_nxt  = 1'b1;
          out_wait_nxt   = wait_r;
          out_step_nxt   = step_r;
          out_scaled_nxt = (|prod_r[PROD_W-1:STEP_W+8]) ? '1 : prod_r[STEP_W+7:8];
          out_frame_nxt  = frame_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      fill_r      <= '0;
      cnt_r       <= '0;
      acc_v_r     <= 1'b0;
      frame_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      cnt_r       <= cnt_nxt;
      acc_v_r     <= acc_v_nxt;
      frame_r     <= frame_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raw_r        <= raw_nxt;
    act_r        <= act_nxt;
    elapsed_r    <= elapsed_nxt;
    wait_r       <= wait_nxt;
    step_r       <= step_nxt;
    prod_r       <= prod_nxt;
    ptr_r        <= ptr_nxt;
    sum_r        <= sum_nxt;
    out_wait_r   <= out_wait_nxt;
    out_step_r   <= out_step_nxt;
    out_scaled_r <= out_scaled_nxt;
    out_frame_r  <= out_frame_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) hist_mem[head_r] <= elapsed_r;
    if (rd_en) rd_data_r <= hist_mem[ptr_r];
  end

  assign in_chan.ready           = rst_n && (state_r == S_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.wait_us        = out_wait_r;
  assign out_chan.step_us        = out_step_r;
  assign out_chan.scaled_step_us = out_scaled_r;
  assign out_chan.frame_number   = out_frame_r;

  `FIPS_ASSERT_IMP(a_start_idle_div, clk, rst_n, div_start, !div_stat.busy,
                   "divider started while busy")
  `FIPS_ASSERT_IMP(a_sum_fill_window, clk, rst_n, state_r == S_SUM, fill_r == n_w,
                   "history fill differs from window while summing")
  `FIPS_ASSERT_IMP(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FW'(DEPTH),
                   "history fill beyond depth")

endmodule

`default_nettype wire

FILE: dv/fips_checker.sv
`default_nettype none

module fips_checker
  import fips_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  fips_in_if                         in_mon,
  fips_out_if                        out_mon,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic                  cfg_pready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  wire logic                  run_done,
  output int                         fail_count
);

  localparam int DEPTH = 64;

  typedef struct packed {
    logic [WAIT_W-1:0]  wait_us;
    logic [STEP_W-1:0]  step_us;
    logic [STEP_W-1:0]  scaled_step_us;
    logic [FRAME_W-1:0] frame_number;
  } paced_frame_t;

  logic [RATE_W-1:0]  cap_active;
  logic [RATE_W-1:0]  cap_inactive;
  logic [RATE_W-1:0]  floor_rate;
  logic [WIN_W-1:0]   window;
  logic [SCALE_W-1:0] scale;
  logic [STEP_W-1:0]  interval_log [DEPTH];
  int unsigned        log_fill;
  logic [5:0]         log_head;
  logic [FRAME_W-1:0] frame_count;
  paced_frame_t       paced_frames [$];
  paced_frame_t       want;
  logic               leftovers_checked;

  function automatic paced_frame_t pace_frame(logic [RAW_W-1:0] raw, logic active);
    paced_frame_t      res;
    logic [RATE_W-1:0] cap;
    logic [STEP_W-1:0] elapsed;
    logic [STEP_W-1:0] period;
    logic [63:0]       sum;
    logic [63:0]       prod;
    logic [5:0]        slot;
    int unsigned       n;
    int unsigned       held;
    int unsigned       k;
    res = '0;
    cap = cap_active;
    elapsed = raw;
    if (!active && cap != 0 && cap_inactive < cap) cap = cap_inactive;
    if (cap != 0) begin
      period = MICROS_PER_SECOND / cap;
      if (elapsed < period) begin
        res.wait_us = WAIT_W'(period - elapsed);
        elapsed = period;
      end
    end
    if (floor_rate != 0) begin
      period = MICROS_PER_SECOND / floor_rate;
      if (elapsed > period) elapsed = period;
    end
    res.step_us = elapsed;
    if (window != 0) begin
      n = (window > DEPTH) ? DEPTH : window;
      interval_log[log_head] = elapsed;
      log_head = log_head + 6'd1;
      held = log_fill + 1;
      if (held > n) begin
        sum = '0;
        for (k = 1; k <= n; k++) begin
          slot = log_head - 6'(k);
          sum += 64'(interval_log[slot]);
        end
        res.step_us = STEP_W'(sum / n);
        log_fill = n;
      end else begin
        log_fill = held;
      end
    end
    prod = (64'(res.step_us) * 64'(scale)) >> 8;
    res.scaled_step_us = (prod > 64'hFFFF_FFFF) ? '1 : prod[STEP_W-1:0];
    frame_count = frame_count + 64'd1;
    res.frame_number = frame_count;
    return res;
  endfunction

  task automatic compare_field(string field, logic [63:0] exp_val, logic [63:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, got_val);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cap_active = '0;
      cap_inactive = '0;
      floor_rate = '0;
      window = '0;
      scale = SCALE_ONE;
      log_fill = 0;
      log_head = '0;
      frame_count = '0;
      paced_frames.delete();
      leftovers_checked = 1'b0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[CFG_ADDR_W-1:2])
          REG_CAP_ACTIVE:   cap_active = cfg_pwdata[RATE_W-1:0];
          REG_CAP_INACTIVE: cap_inactive = cfg_pwdata[RATE_W-1:0];
          REG_FLOOR_RATE:   floor_rate = cfg_pwdata[RATE_W-1:0];
          REG_SMOOTH_WIN:   window = cfg_pwdata[WIN_W-1:0];
          REG_SCALE:        scale = cfg_pwdata[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        paced_frames.insert(paced_frames.size(),
                            pace_frame(in_mon.raw_interval_us, in_mon.app_active));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (paced_frames.size() == 0) begin
          $display("%0t: result beat with nothing pending, step_us %0d frame_number %0d",
                   $time, out_mon.step_us, out_mon.frame_number);
          fail_count++;
        end else begin
          want = paced_frames.pop_front();
          compare_field("wait_us", 64'(want.wait_us), 64'(out_mon.wait_us));
          compare_field("step_us", 64'(want.step_us), 64'(out_mon.step_us));
          compare_field("scaled_step_us", 64'(want.scaled_step_us),
                        64'(out_mon.scaled_step_us));
          compare_field("frame_number", want.frame_number, out_mon.frame_number);
        end
      end
      if (run_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (paced_frames.size() != 0) begin
          $display("%0t: %0d results never arrived", $time, paced_frames.size());
          fail_count += paced_frames.size();
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none

module testbench;
  import fips_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 4_000_000;
  localparam int unsigned LONG_HOLD = 600;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_FRAMES = 119;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  logic                  run_done;
  logic                  quiet = 1'b0;
  logic                  hold_req = 1'b0;
  int                    fail_count;
  int unsigned           frames_sent = 0;
  int unsigned           results_seen = 0;
  int unsigned           settings_used = 1;

  fips_in_if  in_chan ();
  fips_out_if out_chan ();

  frame_interval_pacer_smoother uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  fips_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .run_done    (run_done),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (out_chan.valid && out_chan.ready) results_seen <= results_seen + 1;
  end

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 200);
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return $urandom_range(0, 2000);
      3: return $urandom_range(0, 100000);
      4: return $urandom_range(900000, 1100000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2: return RATE_W'(1);
      3: return '1;
      4: return RATE_W'(1000);
      default: return RATE_W'($urandom_range(1, 1023));
    endcase
  endfunction

  function automatic logic [WIN_W-1:0] pick_window();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return WIN_W'(64);
      2: return WIN_W'($urandom_range(65, 127));
      default: return WIN_W'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return SCALE_ONE;
      default: return SCALE_W'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] with_noise(logic [CFG_DATA_W-1:0] field, int w);
    return (CFG_DATA_W'($urandom()) << w) | field;
  endfunction

  // Hold psel high across back-to-back beats; program_regs drops it.
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  task automatic program_regs(logic [RATE_W-1:0] cap_a, logic [RATE_W-1:0] cap_i,
                              logic [RATE_W-1:0] flr, logic [WIN_W-1:0] win,
                              logic [SCALE_W-1:0] scl);
    write_reg(REG_CAP_ACTIVE, with_noise(CFG_DATA_W'(cap_a), RATE_W));
    write_reg(REG_CAP_INACTIVE, with_noise(CFG_DATA_W'(cap_i), RATE_W));
    write_reg(REG_FLOOR_RATE, with_noise(CFG_DATA_W'(flr), RATE_W));
    write_reg(REG_SMOOTH_WIN, with_noise(CFG_DATA_W'(win), WIN_W));
    write_reg(REG_SCALE, with_noise(CFG_DATA_W'(scl), SCALE_W));
    if ($urandom_range(0, 2) == 0) begin
      write_reg(REG_SCALE + REG_IDX_W'($urandom_range(1, 3)), $urandom());
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    settings_used++;
  endtask

  task automatic drain();
    do @(posedge clk); while (results_seen != frames_sent);
  endtask

  task automatic send_frame(logic [RAW_W-1:0] raw, logic active);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.raw_interval_us <= raw;
    in_chan.app_active <= active;
    do @(posedge clk); while (!in_chan.ready);
    frames_sent++;
  endtask

  task automatic finish_batch();
    in_chan.valid <= 1'b0;
    drain();
  endtask

  task automatic random_phase(int unsigned frames, bit pause_midway);
    int unsigned i;
    for (i = 0; i < frames; i++) begin
      if (pause_midway && i == frames / 2) finish_batch();
      send_frame(pick_raw(), 1'($urandom_range(0, 1)));
    end
    finish_batch();
  endtask

  initial begin : result_sink
    logic        rdy;
    int unsigned span;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        rdy = 1'b0;
        span = LONG_HOLD;
      end else if (quiet) begin
        rdy = 1'b1;
        span = 1;
      end else begin
        rdy = ($urandom_range(0, 2) != 0);
        span = rdy ? $urandom_range(1, 16) : pick_gap() + 1;
      end
      out_chan.ready <= rdy;
      repeat (span) @(posedge clk);
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d of %0d results seen",
             cycles, results_seen, frames_sent);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int unsigned p;
    rst_n <= 1'b0;
    run_done <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    in_chan.valid <= 1'b0;
    in_chan.raw_interval_us <= '0;
    in_chan.app_active <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(32'd0, 1'b1);
    send_frame('1, 1'b0);
    send_frame(32'd12345, 1'b1);
    finish_batch();

    program_regs(10'd60, 10'd30, 10'd10, 7'd0, 16'hFFFF);
    send_frame(32'd0, 1'b1);
    send_frame(32'd0, 1'b0);
    send_frame(32'd5000000, 1'b1);
    send_frame(32'd20000, 1'b0);
    send_frame('1, 1'b1);
    finish_batch();

    program_regs(10'd1, 10'd0, 10'd0, 7'd127, 16'hFFFF);
    send_frame(32'd0, 1'b1);
    send_frame(32'd0, 1'b0);
    send_frame('1, 1'b0);
    send_frame('1, 1'b1);
    finish_batch();

    program_regs(10'd500, 10'd1023, 10'd1023, 7'd4, 16'd0);
    send_frame(32'd0, 1'b0);
    send_frame(32'd1500, 1'b1);
    send_frame('1, 1'b0);
    send_frame(32'd999, 1'b1);
    send_frame(32'd5000, 1'b0);
    send_frame(32'd2000, 1'b1);
    finish_batch();

    program_regs(10'd1023, 10'd1, 10'd1, 7'd2, SCALE_ONE);
    send_frame(32'd0, 1'b0);
    send_frame(32'd700, 1'b1);
    send_frame('1, 1'b1);
    finish_batch();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        program_regs('1, '1, '1, '1, '1);
      end else if (p == RANDOM_PHASES - 1) begin
        program_regs(10'd1, 10'd1, 10'd1, 7'd1, 16'd1);
      end else begin
        program_regs(pick_rate(), pick_rate(), pick_rate(), pick_window(), pick_scale());
      end
      quiet = (p == 1 || p == 7);
      if (p == 3) hold_req = 1'b1;
      random_phase(PHASE_FRAMES, p == 5);
      quiet = 1'b0;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Covered %0d frames under %0d register settings: caps, floors and windows",
             frames_sent, settings_used);
    $display("at both extremes, scale saturation, a %0d-cycle output stall, mid-phase drain.",
             LONG_HOLD);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+hw/rtl
hw/rtl/fips_pkg.sv
hw/rtl/fips_in_if.sv
hw/rtl/fips_out_if.sv
hw/rtl/fips_div.sv
hw/rtl/frame_interval_pacer_smoother.sv
dv/fips_checker.sv
dv/testbench.sv
